/* rtl/ekt_pkg.sv */
// ============================================================================
// ekt_pkg
// Shared types and constants for the expiring key table.
// ============================================================================
package ekt_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_W      = 64;
    localparam int STAMP_W    = 64;
    localparam int EXP_W      = 32;
    localparam int OCC_W      = 5;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int ENTRY_W    = KEY_W + STAMP_W;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IPV4_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_MS    = 1'd1;

    localparam logic [EXP_W-1:0] EXPIRY_RESET = 32'd60000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key_hash;
        logic [STAMP_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_EQ  = 2'd0,
        OP_LT  = 2'd1,
        OP_AGE = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [STAMP_W-1:0] a;
        logic [STAMP_W-1:0] b;
    } t_alu_req;

endpackage

/* rtl/expiring_key_table_oldest_evict_core.sv */
// ============================================================================
// expiring_key_table_oldest_evict_core
// Ordered table of keys with time stamps; lookup, refresh, expiry and
// oldest-stamp eviction run by a sequencer around one shared compare unit.
// ============================================================================
// Clear, ignored mark or unused command go straight to DONE; queries and
//   marks scan the table first. One item at a time: the next item is taken
//   the cycle after the result loads; each scan step is one RAM read plus
//   one pass through the shared compare unit.
// Reset: synchronous, active low; table empty, marks disabled, expiry 60000.
//   The entry RAM is not cleared; only entries below the count are read.
module expiring_key_table_oldest_evict_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ekt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ekt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ekt_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ekt_pkg::t_out_item                 o_out_item
);
    import ekt_pkg::*;

    // Sequencer states
    //   FIND   : walk entries comparing keys
    //   AGE    : check age of the matching entry (query)
    //   MIN    : walk a full table for the oldest stamp
    //   DROP   : start removal at r_pos
    //   SHIFT  : move entries above r_pos down by one
    //   APPEND : write new entry at the tail
    //   DONE   : hand result to the output register
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FIND   = 8'b0000_0010,
        S_AGE    = 8'b0000_0100,
        S_MIN    = 8'b0000_1000,
        S_DROP   = 8'b0001_0000,
        S_SHIFT  = 8'b0010_0000,
        S_APPEND = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic [STAMP_W-1:0]   r_stamp, n_stamp;
    logic                 r_hit, n_hit;
    logic [CMD_W-1:0]     r_cmd;
    logic [KEY_W-1:0]     r_key;
    logic [STAMP_W-1:0]   r_now;
    logic                 r_ipv4;
    logic [EXP_W-1:0]     r_expiry;
    logic                 r_out_valid;
    t_out_item            r_out;

    // entry RAM: {key, stamp}
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [KEY_W-1:0]     rd_key;
    logic [STAMP_W-1:0]   rd_stamp;

    t_alu_req             alu_req;
    logic                 alu_flag;

    logic                 in_fire;
    logic                 out_load;
    logic                 is_mark;
    logic [CNT_W-1:0]     last_idx;
    logic [CNT_W-1:0]     idx_ext;
    logic [CNT_W-1:0]     pos_ext;
    logic [CNT_W:0]       idx_p1;
    logic [CNT_W:0]       idx_p2;
    logic [CNT_W:0]       pos_p1;

    assign rd_key   = ram_rdata[ENTRY_W-1 -: KEY_W];
    assign rd_stamp = ram_rdata[STAMP_W-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign is_mark  = (r_cmd == CMD_MARK);
    assign last_idx = r_count - CNT_W'(1);
    assign idx_ext  = CNT_W'(r_idx);
    assign pos_ext  = CNT_W'(r_pos);
    assign idx_p1   = {1'b0, idx_ext} + (CNT_W+1)'(1);
    assign idx_p2   = {1'b0, idx_ext} + (CNT_W+1)'(2);
    assign pos_p1   = {1'b0, pos_ext} + (CNT_W+1)'(1);

    ekt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ekt_alu u_alu (
        .i_req   (alu_req),
        .i_limit (r_expiry),
        .o_flag  (alu_flag)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_stamp   = r_stamp;
        n_hit     = r_hit;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {r_key, r_now};
        ram_raddr = '0;
        alu_req   = '{op: OP_EQ, a: rd_key, b: r_key};
        out_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_hit = 1'b0;
                    n_idx = '0;
                    case (i_in_item.cmd)
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        CMD_MARK: begin
                            if (!r_ipv4) begin
                                n_state = S_DONE;
                            end else if (r_count == '0) begin
                                n_state = S_APPEND;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        CMD_QUERY: begin
                            n_state = (r_count == '0) ? S_DONE : S_FIND;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_FIND: begin
                // rd_key holds entry r_idx
                alu_req = '{op: OP_EQ, a: rd_key, b: r_key};
                if (alu_flag) begin
                    n_pos   = r_idx;
                    n_stamp = rd_stamp;
                    if (is_mark) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_idx;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_AGE;
                    end
                end else if (idx_ext == last_idx) begin
                    if (!is_mark) begin
                        n_state = S_DONE;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_idx   = '0;
                        n_state = S_MIN;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else begin
                    n_idx     = IDX_W'(idx_p1);
                    ram_raddr = IDX_W'(idx_p1);
                end
            end

            S_AGE: begin
                alu_req = '{op: OP_AGE, a: r_now, b: r_stamp};
                if (alu_flag) begin
                    n_state = S_DROP;
                end else begin
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_MIN: begin
                // strict less-than: earliest entry wins a tie
                alu_req = '{op: OP_LT, a: rd_stamp, b: r_stamp};
                if ((r_idx == '0) || alu_flag) begin
                    n_stamp = rd_stamp;
                    n_pos   = r_idx;
                end
                if (idx_ext == last_idx) begin
                    n_state = S_DROP;
                end else begin
                    n_idx     = IDX_W'(idx_p1);
                    ram_raddr = IDX_W'(idx_p1);
                end
            end

            S_DROP: begin
                if (pos_ext == last_idx) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = is_mark ? S_APPEND : S_DONE;
                end else begin
                    n_idx     = r_pos;
                    ram_raddr = IDX_W'(pos_p1);
                    n_state   = S_SHIFT;
                end
            end

            S_SHIFT: begin
                // ram_rdata holds entry r_idx+1
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                if (idx_p2 < {1'b0, r_count}) begin
                    n_idx     = IDX_W'(idx_p1);
                    ram_raddr = IDX_W'(idx_p2);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = is_mark ? S_APPEND : S_DONE;
                end
            end

            S_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_count);
                n_count   = r_count + CNT_W'(1);
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pos       <= '0;
            r_hit       <= 1'b0;
            r_ipv4      <= 1'b0;
            r_expiry    <= EXPIRY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_hit   <= n_hit;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IPV4_ENABLED: r_ipv4   <= i_cfg_data[0];
                    CFG_EXPIRY_MS:    r_expiry <= i_cfg_data[EXP_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
        if (in_fire) begin
            r_cmd <= i_in_item.cmd;
            r_key <= i_in_item.key_hash;
            r_now <= i_in_item.now_ms;
        end
        if (out_load) begin
            r_out.hit       <= r_hit;
            r_out.occupancy <= OCC_W'(r_count);
        end
    end

endmodule

/* rtl/ekt_ram.sv */
// ============================================================================
// ekt_ram
// Single write port, single read port RAM with registered read data.
// ============================================================================
module ekt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/ekt_alu.sv */
// ============================================================================
// ekt_alu
// Shared 64-bit compare unit: key equality, stamp order, age limit.
// ============================================================================
module ekt_alu (
    input  ekt_pkg::t_alu_req              i_req,
    input  logic [ekt_pkg::EXP_W-1:0]      i_limit,
    output logic                           o_flag
);
    import ekt_pkg::*;

    logic [STAMP_W-1:0] diff;

    // wrapping age: now - stamp, modulo 2^64
    assign diff = i_req.a - i_req.b;

    always_comb begin
        case (i_req.op)
            OP_EQ:   o_flag = (i_req.a == i_req.b);
            OP_LT:   o_flag = (i_req.a < i_req.b);
            OP_AGE:  o_flag = (diff > {{(STAMP_W - EXP_W){1'b0}}, i_limit});
            default: o_flag = 1'b0;
        endcase
    end

endmodule

/* rtl/ekt_checker.sv */
// ============================================================================
// ekt_checker
// Port-level checks for the expiring key table, bound to the top level.
// ============================================================================
module ekt_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  ekt_pkg::t_in_item                  i_in_item,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  ekt_pkg::t_out_item                 o_out_item
);
    import ekt_pkg::*;

    logic             push;
    logic             pop;
    logic [1:0]       r_npend;
    logic [CMD_W-1:0] r_cmd_a;
    logic [CMD_W-1:0] r_cmd_b;

    assign push = i_in_valid && o_in_ready;
    assign pop  = o_out_valid && i_out_ready;

    // commands of items whose results are not yet taken, oldest in r_cmd_a
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_npend <= '0;
        end else begin
            case ({push, pop})
                2'b10: begin
                    if (r_npend == 2'd0) begin
                        r_cmd_a <= i_in_item.cmd;
                    end else begin
                        r_cmd_b <= i_in_item.cmd;
                    end
                    if (r_npend != 2'd3) begin
                        r_npend <= r_npend + 2'd1;
                    end
                end
                2'b01: begin
                    r_cmd_a <= r_cmd_b;
                    if (r_npend != 2'd0) begin
                        r_npend <= r_npend - 2'd1;
                    end
                end
                2'b11: begin
                    if (r_npend == 2'd1) begin
                        r_cmd_a <= i_in_item.cmd;
                    end else begin
                        r_cmd_a <= r_cmd_b;
                        r_cmd_b <= i_in_item.cmd;
                    end
                end
                default: ;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item dropped or changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_npend != 2'd0)
        else $error("result item with no accepted input item");

    a_hit_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.hit |-> r_cmd_a == CMD_QUERY)
        else $error("hit reported for a command other than query");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_npend != 2'd0) && (r_cmd_a == CMD_CLEAR)
        |-> o_out_item.occupancy == '0)
        else $error("clear left entries in the table");

endmodule

bind expiring_key_table_oldest_evict_core ekt_checker u_ekt_checker (.*);

/* bench/expiring_key_table_oldest_evict_core_test.sv */
// ============================================================================
// expiring_key_table_oldest_evict_core_test
// Self-checking bench for the expiring key table. A short directed script
// covers reset behavior, the disabled-mark gate, a full table with a stamp
// tie on eviction, the expiry boundary, time running backwards and clear.
// Random phases follow, each with its own register setting. A table model
// predicts each unpinned result, and results are compared in order.
// ============================================================================
module expiring_key_table_oldest_evict_core_test;
    import ekt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned RUN_LIMIT     = 400000;
    localparam int unsigned SETTLE_CYCLES = 3 * CAPACITY + 4;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned HOLD_AFTER    = 400;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned PHASE_ITEMS   = 135;
    localparam int unsigned KEY_POOL      = 20;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_REG  = 1'b1
    } t_row_kind;

    // one line of the directed script: an item or a register write
    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_data;
        t_in_item                item;
        logic                    pinned;
        t_out_item               pin;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_item;

    // typed-in expectation riding along with the current item
    logic               pin_on = 1'b0;
    t_out_item          pin_result = '0;

    // local copy of the table and its registers
    logic [KEY_W-1:0]   tbl_key   [CAPACITY];
    logic [STAMP_W-1:0] tbl_stamp [CAPACITY];
    int unsigned        tbl_count = 0;
    logic               tbl_marks_on = 1'b0;
    logic [EXP_W-1:0]   tbl_expiry = EXPIRY_RESET;

    t_out_item          lookup_answers [$];
    t_row               script [$];
    logic [KEY_W-1:0]   key_pool [KEY_POOL];
    logic [STAMP_W-1:0] clock_ms = '0;
    logic [31:0]        step_ms = 1;
    int unsigned        mark_bias = 50;
    int unsigned        burst_left = 0;
    int unsigned        requests_taken = 0;
    int unsigned        faults = 0;
    int unsigned        cycle_count = 0;

    expiring_key_table_oldest_evict_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------------
    function automatic int tbl_find(input logic [KEY_W-1:0] key);
        for (int i = 0; i < int'(tbl_count); i++) begin
            if (tbl_key[i] == key) return i;
        end
        return -1;
    endfunction

    // remove one entry, later entries slide down to keep insertion order
    function automatic void tbl_drop(input int pos);
        for (int i = pos; i + 1 < int'(tbl_count); i++) begin
            tbl_key[i]   = tbl_key[i + 1];
            tbl_stamp[i] = tbl_stamp[i + 1];
        end
        tbl_count--;
    endfunction

    function automatic t_out_item cache_apply(input t_in_item it);
        t_out_item          res;
        int                 pos;
        int                 oldest;
        logic [STAMP_W-1:0] age;
        res = '0;
        case (it.cmd)
            CMD_MARK: begin
                if (tbl_marks_on) begin
                    pos = tbl_find(it.key_hash);
                    if (pos >= 0) begin
                        tbl_stamp[pos] = it.now_ms;
                    end else begin
                        if (tbl_count >= CAPACITY) begin
                            // strict compare: on a tie the lowest index goes
                            oldest = 0;
                            for (int i = 1; i < CAPACITY; i++) begin
                                if (tbl_stamp[i] < tbl_stamp[oldest]) oldest = i;
                            end
                            tbl_drop(oldest);
                        end
                        tbl_key[tbl_count]   = it.key_hash;
                        tbl_stamp[tbl_count] = it.now_ms;
                        tbl_count++;
                    end
                end
            end
            CMD_QUERY: begin
                pos = tbl_find(it.key_hash);
                if (pos >= 0) begin
                    age = it.now_ms - tbl_stamp[pos];   // wraps when time goes back
                    if (age > {32'd0, tbl_expiry}) begin
                        tbl_drop(pos);
                    end else begin
                        res.hit = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                tbl_count = 0;
            end
            default: begin
            end
        endcase
        res.occupancy = tbl_count[OCC_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: results are checked before the new item is predicted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = o_out_item;
                if (lookup_answers.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got hit=%0d occupancy=%0d",
                             $time, got.hit, got.occupancy);
                    faults++;
                end else begin
                    want = lookup_answers.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit mismatch: expected %0d, got %0d",
                                 $time, want.hit, got.hit);
                        faults++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $display("%0t: occupancy mismatch: expected %0d, got %0d",
                                 $time, want.occupancy, got.occupancy);
                        faults++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = cache_apply(i_in_item);
                if (pin_on) want = pin_result;
                lookup_answers.push_back(want);
                requests_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("expiring_key_table_oldest_evict_core_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: stall patterns, plus one long hold-off once traffic is up
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned mode;
        int unsigned span;
        bit          held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!held && requests_taken >= HOLD_AFTER) begin
                held = 1'b1;
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (int k = 0; k < int'(span); k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= (k % 3) != 0;
                    default: i_out_ready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic offer_item(input t_in_item it, input logic pinned, input t_out_item pin);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        pin_on     <= pinned;
        pin_result <= pin;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic pause_sender();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain_results();
        while (lookup_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_IPV4_ENABLED) tbl_marks_on = data[0];
        else                         tbl_expiry   = data[EXP_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_row row_item(input logic [CMD_W-1:0] cmd,
                                      input logic [KEY_W-1:0] key,
                                      input logic [STAMP_W-1:0] now);
        t_row r;
        r = '0;
        r.kind          = ROW_ITEM;
        r.item.cmd      = cmd;
        r.item.key_hash = key;
        r.item.now_ms   = now;
        return r;
    endfunction

    function automatic t_row row_pinned(input logic [CMD_W-1:0] cmd,
                                        input logic [KEY_W-1:0] key,
                                        input logic [STAMP_W-1:0] now,
                                        input logic hit, input logic [OCC_W-1:0] occ);
        t_row r;
        r = row_item(cmd, key, now);
        r.pinned        = 1'b1;
        r.pin.hit       = hit;
        r.pin.occupancy = occ;
        return r;
    endfunction

    function automatic t_row row_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = '0;
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    // random item: pool keys so lookups land, time mostly creeping forward
    function automatic t_in_item next_random_item();
        t_in_item    it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 1)              it.cmd = CMD_CLEAR;
        else if (pick < 3)         it.cmd = CMD_UNUSED;
        else if (pick < mark_bias) it.cmd = CMD_MARK;
        else                       it.cmd = CMD_QUERY;
        if ($urandom_range(0, 9) != 0) it.key_hash = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else                           it.key_hash = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0, 1:   clock_ms = clock_ms;
            16, 17: clock_ms = clock_ms + $urandom_range(0, 3 * step_ms);
            18:     clock_ms = {$urandom, $urandom};
            19:     clock_ms = clock_ms - $urandom_range(1, 1000);
            default: clock_ms = clock_ms + $urandom_range(0, step_ms);
        endcase
        it.now_ms = clock_ms;
        return it;
    endfunction

    initial begin : stimulus
        int unsigned      run_left;
        logic             phase_on;
        logic [EXP_W-1:0] phase_exp;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset marks are gated off and the table is empty
        script.push_back(row_pinned(CMD_MARK, 64'd0, 64'd0, 1'b0, 5'd0));
        script.push_back(row_pinned(CMD_QUERY, '1, '1, 1'b0, 5'd0));
        script.push_back(row_pinned(CMD_UNUSED, 64'd5, 64'd5, 1'b0, 5'd0));
        script.push_back(row_reg(CFG_IPV4_ENABLED, 32'd1));
        // fill to capacity; keys 3 and 5 share the smallest stamp
        script.push_back(row_pinned(CMD_MARK, 64'd0, 64'd1001, 1'b0, 5'd1));
        script.push_back(row_pinned(CMD_MARK, '1, 64'd1002, 1'b0, 5'd2));
        script.push_back(row_pinned(CMD_MARK, 64'd3, 64'd7, 1'b0, 5'd3));
        script.push_back(row_pinned(CMD_MARK, 64'd4, 64'd1004, 1'b0, 5'd4));
        script.push_back(row_pinned(CMD_MARK, 64'd5, 64'd7, 1'b0, 5'd5));
        for (int k = 6; k <= CAPACITY; k++) begin
            script.push_back(row_pinned(CMD_MARK, 64'(k), 64'(1000 + k), 1'b0, OCC_W'(k)));
        end
        // new key on a full table: tie goes to key 3, nearer the front
        script.push_back(row_item(CMD_MARK, 64'd17, 64'd2000));
        // age exactly at the limit is kept, one past it expires
        script.push_back(row_item(CMD_QUERY, 64'd5, 64'd60007));
        script.push_back(row_item(CMD_QUERY, 64'd5, 64'd60008));
        // time going backwards: the age wraps huge, entry expires
        script.push_back(row_item(CMD_QUERY, '1, 64'd0));
        script.push_back(row_item(CMD_MARK, 64'd6, '1));
        script.push_back(row_item(CMD_QUERY, 64'd6, '1));
        script.push_back(row_pinned(CMD_CLEAR, 64'hAAAA_AAAA_AAAA_AAAA,
                                    64'h5555_5555_5555_5555, 1'b0, 5'd0));

        foreach (script[r]) begin
            if (script[r].kind == ROW_REG) begin
                pause_sender();
                drain_results();
                write_reg(script[r].reg_idx, script[r].reg_data);
            end else begin
                offer_item(script[r].item, script[r].pinned, script[r].pin);
            end
        end

        foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
        clock_ms = 64'd100000;
        run_left = 0;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            phase_on = 1'b1;
            case (p)
                0: phase_exp = EXPIRY_RESET;
                1: phase_exp = '0;
                2: phase_exp = '1;
                3: begin
                    phase_exp = 32'd5000;
                    phase_on  = 1'b0;     // table carries over, marks bounce
                end
                4: phase_exp = $urandom;
                5: phase_exp = 32'd1;
                6: phase_exp = 32'd1000;
                default: phase_exp = 32'd250;
            endcase
            pause_sender();
            drain_results();
            write_reg(CFG_IPV4_ENABLED, {31'd0, phase_on});
            write_reg(CFG_EXPIRY_MS, phase_exp);
            step_ms = (phase_exp < 6) ? 32'd1 : phase_exp / 6;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // runs that mostly fill, then runs that mostly look up
                if (run_left == 0) begin
                    run_left  = $urandom_range(4, 30);
                    mark_bias = $urandom_range(0, 1) ? 80 : 30;
                end
                run_left--;
                offer_item(next_random_item(), 1'b0, '0);
            end
        end

        pause_sender();
        while (lookup_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (lookup_answers.size() != 0) faults++;
        if (faults == 0) begin
            $display("expiring_key_table_oldest_evict_core_test: clean");
        end else begin
            $display("expiring_key_table_oldest_evict_core_test: errors");
        end
        $finish;
    end

endmodule
